@@ rtl/core/pba_pkg.sv @@
package pba_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_PORTS = 1024;
    localparam int DEF_WORD_BITS = 64;

    // Field and internal widths
    localparam int PORT_W = 16;
    localparam int CNT_W  = 11;
    localparam int IDX_W  = 12;   // window index and scan base; window never exceeds 2047
    localparam int WIN_W  = 17;   // window size before clamping, holds 65536
    localparam int CFG_W  = 16;
    localparam int CFG_IDX_W = 1;

    typedef logic [1:0] cmd_t;

    localparam cmd_t CMD_CLAIM   = 2'd0;
    localparam cmd_t CMD_ANY     = 2'd1;
    localparam cmd_t CMD_RELEASE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_PORT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PORT_COUNT = 1'd1;

    localparam logic [CNT_W-1:0] PORT_COUNT_RST = 11'd1024;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic check;
        logic eval;
        logic clear;
        logic deliver;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
        logic start_fail;
        logic eval_stop;
        logic out_free;
    } ctrl_sts_t;

endpackage

@@ rtl/core/port_bitmap_allocator_core.sv @@
// Port bitmap allocator: one in-use bit per port in a window starting at base_port.
// Requests arrive on in_valid/in_ready with cmd and port; each request gives one
// result on out_valid/out_ready carrying ok and port_out.
// Commands: claim a named port, claim the lowest free port, release a named port.
// Configuration (base_port, port_count) is written through cfg_we/cfg_index/cfg_wdata
// only while no request is in flight; the user must keep to this, as the block
// does not enforce it. The bits stay attached to window indexes.
// Timing: one request at a time. An accepted request is checked against the window,
// then scans W bitmap words, then is delivered to out_valid, where W is up to
// ceil(window / WORD_BITS) (16 with the defaults) for claim-any, and for named
// commands the word holding the port plus the words before it, one word read per
// cycle from the single read port of the bitmap memory. Requests failing the
// window check skip the scan (W = 0). in_ready rises together with out_valid.
// Reset: base_port = 0, port_count = 1024, and a clearing pass writes zeros to
// every one of the WORD_COUNT bitmap words (16 with the defaults), one per cycle,
// with in_ready low throughout.
// A stalled receiver holds the result in the output register; the next request
// is accepted and processed meanwhile, then waits until that register is free.
module port_bitmap_allocator_core #(
    parameter int MAX_PORTS = pba_pkg::DEF_MAX_PORTS,
    parameter int WORD_BITS = pba_pkg::DEF_WORD_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  pba_pkg::cmd_t                 cmd,
    input  logic [pba_pkg::PORT_W-1:0]    port,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          ok,
    output logic [pba_pkg::PORT_W-1:0]    port_out,
    input  logic                          cfg_we,
    input  logic [pba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pba_pkg::CFG_W-1:0]     cfg_wdata
);

    import pba_pkg::*;

    ctrl_cmd_t ctrl_cmd;
    ctrl_sts_t ctrl_sts;

    pba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd_o    (ctrl_cmd),
        .sts_i    (ctrl_sts)
    );

    pba_datapath #(
        .MAX_PORTS (MAX_PORTS),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_i     (ctrl_cmd),
        .sts_o     (ctrl_sts),
        .cmd       (cmd),
        .port      (port),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ok        (ok),
        .port_out  (port_out)
    );

endmodule

@@ rtl/core/pba_ram.sv @@
module pba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/pba_ctrl.sv @@
module pba_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output pba_pkg::ctrl_cmd_t cmd_o,
    input  pba_pkg::ctrl_sts_t sts_i
);

    import pba_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_EVAL  = 3'd3;
    localparam logic [2:0] ST_PEND  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd_o      = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd_o.clear = 1'b1;
                if (sts_i.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_o.accept = 1'b1;
                    state_next   = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd_o.check = 1'b1;
                state_next  = sts_i.start_fail ? ST_PEND : ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd_o.eval = 1'b1;
                if (sts_i.eval_stop)
                begin
                    state_next = ST_PEND;
                end
            end
            ST_PEND:
            begin
                if (sts_i.out_free)
                begin
                    cmd_o.deliver = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

@@ rtl/core/pba_datapath.sv @@
module pba_datapath #(
    parameter int MAX_PORTS = pba_pkg::DEF_MAX_PORTS,
    parameter int WORD_BITS = pba_pkg::DEF_WORD_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pba_pkg::ctrl_cmd_t            cmd_i,
    output pba_pkg::ctrl_sts_t            sts_o,
    input  pba_pkg::cmd_t                 cmd,
    input  logic [pba_pkg::PORT_W-1:0]    port,
    input  logic                          cfg_we,
    input  logic [pba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pba_pkg::CFG_W-1:0]     cfg_wdata,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          ok,
    output logic [pba_pkg::PORT_W-1:0]    port_out
);

    import pba_pkg::*;

    localparam int WORD_COUNT = (MAX_PORTS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int BIT_W      = $clog2(WORD_BITS);

    localparam logic [IDX_W-1:0] WB_IDX    = IDX_W'(WORD_BITS);
    localparam logic [WIN_W-1:0] MAX_WIN   = WIN_W'(MAX_PORTS);
    localparam logic [WIN_W-1:0] PORT_SPAN = WIN_W'(65536);
    localparam logic [AW-1:0]    LAST_ADDR = AW'(WORD_COUNT - 1);

    // Configuration
    logic [PORT_W-1:0] base_port_reg, base_port_next;
    logic [CNT_W-1:0]  port_count_reg, port_count_next;

    // Request and scan state
    cmd_t              cmd_reg, cmd_next;
    logic [PORT_W-1:0] port_reg, port_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  n_reg, n_next;
    logic              in_win_reg, in_win_next;
    logic [AW-1:0]     word_addr_reg, word_addr_next;
    logic [IDX_W-1:0]  word_base_reg, word_base_next;

    // Result and output
    logic              res_ok_reg, res_ok_next;
    logic [PORT_W-1:0] res_port_reg, res_port_next;
    logic              out_valid_reg, out_valid_next;
    logic              ok_reg, ok_next;
    logic [PORT_W-1:0] port_out_reg, port_out_next;

    // Window at accept time
    logic [WIN_W-1:0] win_size;
    logic [WIN_W-1:0] win_limit;
    logic [WIN_W-1:0] port_off;
    logic             port_in_win;

    // Word evaluation
    logic [WORD_BITS-1:0] rd_data;
    logic [WORD_BITS-1:0] wr_data;
    logic [AW-1:0]        rd_addr;
    logic                 mem_we;
    logic [IDX_W-1:0]     remain;
    logic [WORD_BITS-1:0] valid_mask;
    logic [WORD_BITS-1:0] free_bits;
    logic [WORD_BITS-1:0] first_free;
    logic [BIT_W-1:0]     free_idx;
    logic                 any_free;
    logic [IDX_W-1:0]     named_off;
    logic                 named_hit;
    logic [BIT_W-1:0]     bit_sel;
    logic [WORD_BITS-1:0] sel_mask;
    logic                 cur_bit;
    logic                 hit;
    logic                 success;
    logic                 last_word;
    logic                 advance;
    logic [PORT_W-1:0]    grant_port;

    always_comb
    begin
        win_limit = PORT_SPAN - WIN_W'(base_port_reg);
        win_size  = WIN_W'(port_count_reg);
        if (win_size > MAX_WIN)
        begin
            win_size = MAX_WIN;
        end
        if (win_size > win_limit)
        begin
            win_size = win_limit;
        end
        port_off    = WIN_W'(port) - WIN_W'(base_port_reg);
        port_in_win = (port >= base_port_reg) && (port_off < win_size);
    end

    always_comb
    begin
        remain = n_reg - word_base_reg;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            valid_mask[i] = (IDX_W'(i) < remain);
        end
        free_bits  = ~rd_data & valid_mask;
        any_free   = |free_bits;
        first_free = free_bits & (~free_bits + WORD_BITS'(1));
        free_idx   = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (first_free[i])
            begin
                free_idx = free_idx | BIT_W'(i);
            end
        end

        named_off = idx_reg - word_base_reg;
        named_hit = (named_off < WB_IDX);
        bit_sel   = named_off[BIT_W-1:0];
        sel_mask  = WORD_BITS'(1) << bit_sel;
        cur_bit   = |(rd_data & sel_mask);

        grant_port = base_port_reg + PORT_W'(word_base_reg) + PORT_W'(free_idx);

        case (cmd_reg)
            CMD_ANY:
            begin
                hit     = any_free;
                success = any_free;
                wr_data = rd_data | first_free;
            end
            CMD_CLAIM:
            begin
                hit     = named_hit;
                success = !cur_bit;
                wr_data = rd_data | sel_mask;
            end
            default:
            begin
                hit     = named_hit;
                success = 1'b1;
                wr_data = rd_data & ~sel_mask;
            end
        endcase

        last_word = ((word_base_reg + WB_IDX) >= n_reg);
        advance   = cmd_i.eval && !hit && !last_word;
        rd_addr   = advance ? word_addr_reg + AW'(1) : word_addr_reg;
        mem_we    = cmd_i.clear || (cmd_i.eval && hit && success);
    end

    pba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_COUNT)
    ) u_words (
        .clk   (clk),
        .we    (mem_we),
        .waddr (word_addr_reg),
        .wdata (cmd_i.clear ? '0 : wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_comb
    begin
        base_port_next  = base_port_reg;
        port_count_next = port_count_reg;
        cmd_next        = cmd_reg;
        port_next       = port_reg;
        idx_next        = idx_reg;
        n_next          = n_reg;
        in_win_next     = in_win_reg;
        word_addr_next  = word_addr_reg;
        word_base_next  = word_base_reg;
        res_ok_next     = res_ok_reg;
        res_port_next   = res_port_reg;
        out_valid_next  = out_valid_reg;
        ok_next         = ok_reg;
        port_out_next   = port_out_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BASE_PORT:  base_port_next  = cfg_wdata[PORT_W-1:0];
                REG_PORT_COUNT: port_count_next = cfg_wdata[CNT_W-1:0];
                default:        ;
            endcase
        end

        if (cmd_i.clear)
        begin
            word_addr_next = word_addr_reg + AW'(1);
        end

        // Latch the request and freeze the window for its scan
        if (cmd_i.accept)
        begin
            cmd_next       = cmd;
            port_next      = port;
            idx_next       = port_off[IDX_W-1:0];
            n_next         = win_size[IDX_W-1:0];
            in_win_next    = port_in_win;
            word_addr_next = '0;
            word_base_next = '0;
        end

        if (cmd_i.check && sts_o.start_fail)
        begin
            res_ok_next   = 1'b0;
            res_port_next = '0;
        end

        if (cmd_i.eval)
        begin
            if (hit)
            begin
                res_ok_next   = success;
                res_port_next = !success ? '0 :
                                (cmd_reg == CMD_ANY) ? grant_port : port_reg;
            end
            else if (last_word)
            begin
                res_ok_next   = 1'b0;
                res_port_next = '0;
            end
            else
            begin
                word_addr_next = word_addr_reg + AW'(1);
                word_base_next = word_base_reg + WB_IDX;
            end
        end

        if (cmd_i.deliver)
        begin
            out_valid_next = 1'b1;
            ok_next        = res_ok_reg;
            port_out_next  = res_port_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_port_reg  <= '0;
            port_count_reg <= PORT_COUNT_RST;
            word_addr_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            base_port_reg  <= base_port_next;
            port_count_reg <= port_count_next;
            word_addr_reg  <= word_addr_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        port_reg      <= port_next;
        idx_reg       <= idx_next;
        n_reg         <= n_next;
        in_win_reg    <= in_win_next;
        word_base_reg <= word_base_next;
        res_ok_reg    <= res_ok_next;
        res_port_reg  <= res_port_next;
        ok_reg        <= ok_next;
        port_out_reg  <= port_out_next;
    end

    always_comb
    begin
        sts_o.clear_last = (word_addr_reg == LAST_ADDR);
        sts_o.start_fail = (cmd_reg == CMD_ANY) ? (n_reg == '0) :
                           ((cmd_reg == CMD_CLAIM) || (cmd_reg == CMD_RELEASE)) ?
                           !in_win_reg : 1'b1;
        sts_o.eval_stop  = hit || last_word;
        sts_o.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign ok        = ok_reg;
    assign port_out  = port_out_reg;

    // The scan never reads a word that lies wholly beyond the window
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_i.eval |-> (word_base_reg < n_reg))
        else $error("scan went past the window");

    // A failed request always reports port zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (ok_reg || (port_out_reg == '0)))
        else $error("failed result carries a port");

    // A new result is only loaded into a free output slot
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_i.deliver |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before it was taken");

    // A granted named port must match the request
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_i.eval && hit && success && (cmd_reg != CMD_ANY)) |=>
            (res_port_reg == port_reg))
        else $error("named grant does not echo the port");

endmodule

@@ test/tb_port_bitmap_allocator_core.sv @@
`timescale 1ns / 100ps

module tb_port_bitmap_allocator_core;

    import pba_pkg::*;

    localparam cmd_t CMD_UNUSED = 2'd3;
    localparam int   WIN_MAX    = DEF_MAX_PORTS;

    typedef struct packed {
        cmd_t                c;
        logic [PORT_W-1:0]   p;
    } request_t;

    typedef struct packed {
        logic                ok;
        logic [PORT_W-1:0]   port_out;
    } grant_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    cmd_t                  cmd = CMD_CLAIM;
    logic [PORT_W-1:0]     port = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  ok;
    logic [PORT_W-1:0]     port_out;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    // Own copy of the allocator: window registers and in-use bits by window index
    logic [PORT_W-1:0]     win_base = '0;
    logic [CNT_W-1:0]      win_count = PORT_COUNT_RST;
    logic [WIN_MAX-1:0]    port_taken = '0;

    request_t              requests_pending[$];
    grant_t                grants_due[$];

    int errors = 0;
    int requests_sent = 0;
    int results_seen = 0;
    int granted = 0;
    int refused = 0;
    int any_full = 0;
    int settings_used = 0;
    int long_holds = 0;

    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    int hold_mark = 100;
    int stall_mode = 0;
    int mode_left = 0;
    int alt_phase = 0;

    port_bitmap_allocator_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .port      (port),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ok        (ok),
        .port_out  (port_out),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int window_span(int base, int count);
        int n;
        n = count;
        if (n > WIN_MAX)
            n = WIN_MAX;
        if (n > 65536 - base)
            n = 65536 - base;
        return n;
    endfunction

    function automatic grant_t allocate_port(cmd_t c, logic [PORT_W-1:0] p);
        int     span;
        int     offset;
        grant_t g;
        span = window_span(int'(win_base), int'(win_count));
        offset = int'(p) - int'(win_base);
        g = '0;
        case (c)
            CMD_ANY:
            begin
                for (int i = 0; i < span; i++)
                begin
                    if (!port_taken[i])
                    begin
                        port_taken[i] = 1'b1;
                        g.ok = 1'b1;
                        g.port_out = PORT_W'(int'(win_base) + i);
                        break;
                    end
                end
                if (!g.ok)
                    any_full++;
            end
            CMD_CLAIM:
            begin
                if (offset >= 0 && offset < span && !port_taken[offset])
                begin
                    port_taken[offset] = 1'b1;
                    g.ok = 1'b1;
                    g.port_out = p;
                end
            end
            CMD_RELEASE:
            begin
                // releasing a free port still succeeds
                if (offset >= 0 && offset < span)
                begin
                    port_taken[offset] = 1'b0;
                    g.ok = 1'b1;
                    g.port_out = p;
                end
            end
            default:
                g = '0;
        endcase
        return g;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_BASE_PORT)
            win_base = PORT_W'(value);
        else
            win_count = CNT_W'(value);
    endtask

    task automatic apply_window(int base, int count);
        write_reg(REG_BASE_PORT, base);
        write_reg(REG_PORT_COUNT, count);
        settings_used++;
    endtask

    task automatic push_request(cmd_t c, int p);
        request_t r;
        r.c = c;
        r.p = PORT_W'(p);
        requests_pending.push_back(r);
    endtask

    // Mostly ports near the window so that edges, busy ports and full windows come up often
    task automatic queue_random(int base, int count, int num, int any_pct, int rel_pct);
        int span;
        int lo;
        int hi;
        int roll;
        cmd_t c;
        span = window_span(base, count);
        lo = (base >= 3) ? base - 3 : 0;
        hi = base + span + 2;
        if (hi > 65535)
            hi = 65535;
        for (int k = 0; k < num; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < any_pct)
                c = CMD_ANY;
            else if (roll < any_pct + rel_pct)
                c = CMD_RELEASE;
            else if (roll < 97)
                c = CMD_CLAIM;
            else
                c = CMD_UNUSED;
            if ($urandom_range(0, 9) == 0)
                push_request(c, int'($urandom_range(0, 65535)));
            else
                push_request(c, int'($urandom_range(hi, lo)));
        end
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (requests_pending.size() != 0 || in_valid || grants_due.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // Sender: bursts of random length separated by random gaps
    always @(posedge clk)
    begin : request_drive
        logic offering;
        if (rst_n)
        begin
            offering = in_valid;
            if (in_valid && in_ready)
            begin
                grants_due.push_back(allocate_port(cmd, port));
                void'(requests_pending.pop_front());
                requests_sent++;
                offering = 1'b0;
            end
            if (!offering && requests_pending.size() != 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                else
                begin
                    cmd <= requests_pending[0].c;
                    port <= requests_pending[0].p;
                    offering = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
                    end
                end
            end
            in_valid <= offering;
        end
    end

    // Receiver: changing stall pattern, plus long hold-offs while requests are queued
    always @(posedge clk)
    begin : result_accept
        logic rdy;
        rdy = 1'b0;
        if (rst_n)
        begin
            if (hold_left > 0)
                hold_left--;
            else if (results_seen >= hold_mark && in_valid && requests_pending.size() > 20)
            begin
                hold_left = $urandom_range(300, 500);
                hold_mark += 600;
                long_holds++;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 150);
                end
                else
                    mode_left--;
                alt_phase++;
                case (stall_mode)
                    0: rdy = 1'b1;
                    1: rdy = alt_phase[0];
                    2: rdy = ($urandom_range(0, 3) != 0);
                    default: rdy = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
        out_ready <= rdy;
    end

    always @(posedge clk)
    begin : result_check
        grant_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (ok)
                granted++;
            else
                refused++;
            if (grants_due.size() == 0)
            begin
                errors++;
                $display("%0t: result with none expected: ok %0b port_out %0d",
                         $time, ok, port_out);
            end
            else
            begin
                want = grants_due.pop_front();
                if (ok !== want.ok)
                begin
                    errors++;
                    $display("%0t: ok expected %0b actual %0b", $time, want.ok, ok);
                end
                if (port_out !== want.port_out)
                begin
                    errors++;
                    $display("%0t: port_out expected %0d actual %0d",
                             $time, want.port_out, port_out);
                end
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        apply_window(0, 1024);
        push_request(CMD_CLAIM, 0);
        push_request(CMD_CLAIM, 0);
        push_request(CMD_CLAIM, 65535);
        push_request(CMD_CLAIM, 1023);
        push_request(CMD_CLAIM, 1024);
        push_request(CMD_ANY, 0);
        push_request(CMD_RELEASE, 0);
        push_request(CMD_RELEASE, 0);
        push_request(CMD_ANY, 65535);
        push_request(CMD_UNUSED, 65535);
        push_request(CMD_RELEASE, 1024);
        push_request(CMD_RELEASE, 1023);
        wait_idle();

        // window clipped by the top of the port range
        apply_window(65500, 1024);
        push_request(CMD_CLAIM, 65499);
        push_request(CMD_CLAIM, 65535);
        push_request(CMD_ANY, 0);
        push_request(CMD_RELEASE, 65535);
        wait_idle();

        apply_window(65500, 0);
        push_request(CMD_ANY, 0);
        push_request(CMD_CLAIM, 65500);
        push_request(CMD_RELEASE, 65500);
        wait_idle();

        apply_window(65535, 1);
        push_request(CMD_ANY, 0);
        push_request(CMD_RELEASE, 65535);
        push_request(CMD_ANY, 0);
        push_request(CMD_CLAIM, 65534);
        wait_idle();

        apply_window(0, 1024);
        queue_random(0, 1024, 150, 35, 30);
        wait_idle();

        // mostly claim-any requests so that the bitmap fills up and claim-any scans reach deep words
        apply_window(1000, 1024);
        queue_random(1000, 1024, 550, 85, 5);
        wait_idle();

        apply_window(64000, 1024);
        queue_random(64000, 1024, 500, 80, 8);
        wait_idle();

        apply_window(65436, 1024);
        queue_random(65436, 1024, 150, 30, 40);
        wait_idle();

        apply_window(12345, 70);
        queue_random(12345, 70, 150, 40, 35);
        wait_idle();

        apply_window(500, 0);
        queue_random(500, 0, 40, 40, 30);
        wait_idle();

        apply_window(0, 1);
        queue_random(0, 1, 60, 40, 40);
        wait_idle();

        apply_window(65535, 1024);
        queue_random(65535, 1024, 40, 40, 40);
        wait_idle();

        apply_window(300, 1023);
        queue_random(300, 1023, 100, 35, 35);
        wait_idle();

        repeat (25) @(posedge clk);
        if (grants_due.size() != 0)
        begin
            errors++;
            $display("%0t: %0d results expected but never delivered", $time, grants_due.size());
        end
        $display("Ran %0d requests over %0d window settings: %0d granted, %0d refused.",
                 requests_sent, settings_used, granted, refused);
        $display("Claim-any met a full window %0d times; receiver held off %0d times.",
                 any_full, long_holds);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
